[src/bphb_pkg.sv]
// bphb_pkg: shared types, widths and constants of the bar peak-hold ballistics core
// no dependencies
package bphb_pkg;

    // default values for the top level parameters
    localparam int unsigned BANDS_DEF          = 32;
    localparam int unsigned LEVEL_MAX_DEF      = 255;
    localparam int unsigned VELOCITY_START_DEF = 32;

    // field and state widths
    localparam int unsigned BAND_W  = 5;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned ROOF_W  = 10;
    localparam int unsigned VEL_W   = 16;
    localparam int unsigned SUM_W   = 10;   // 2*old + target
    localparam int unsigned QUOT_W  = 14;   // (vel - threshold) / 4

    // ballistics constants
    localparam logic [VEL_W-1:0]   FALL_THRESHOLD = 16'd32;
    localparam logic [ROOF_W-1:0]  ROOF_RESET     = 10'd50;
    localparam logic [LEVEL_W:0]   SMALL_RISE     = 9'd2;
    localparam logic [VEL_W-1:0]   VEL_MAX        = 16'hFFFF;

    // x / 3 for x < 768 as (x * 683) >> 11
    localparam logic [SUM_W-1:0]   DIV3_MUL   = 10'd683;
    localparam int unsigned        DIV3_SHIFT = 11;
    // n / 5 for n < 16384 as (n * 26215) >> 17; /20 is >>2 then /5
    localparam logic [14:0]        DIV5_MUL   = 15'd26215;
    localparam int unsigned        DIV5_SHIFT = 17;

    typedef struct packed {
        logic [LEVEL_W-1:0] bar;
        logic [ROOF_W-1:0]  roof;
        logic [VEL_W-1:0]   vel;
    } entry_t;

endpackage

[src/bphb_ram.sv]
// bphb_ram: generic single write port, single read port ram with registered read
// no dependencies
module bphb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bar_peak_hold_ballistics_core.sv]
// bar_peak_hold_ballistics_core: per-band bar and peak roof ballistics, top level
// depends on bphb_pkg and bphb_ram
//
// Takes one band update per clock while m_ready does not stall the output and gives one
// result item per update. The state of every band (bar, roof, fall velocity) lives in one
// ram with a registered read: an item reads its band when it is accepted, is updated in the
// next cycle and written back as it moves into the output register, which presents the
// result item. An update of the same band in the very next cycle takes the value just
// written through a bypass register, so any band sequence runs at one item per cycle
// while m_ready does not stall the output. Bands never written read as their reset values
// through one valid bit per band, so the block is ready right out of reset. Bands at or
// above BANDS leave the state alone and report zero levels.
module bar_peak_hold_ballistics_core
    import bphb_pkg::*;
#(
    parameter int unsigned BANDS          = BANDS_DEF,
    parameter int unsigned LEVEL_MAX      = LEVEL_MAX_DEF,
    parameter int unsigned VELOCITY_START = VELOCITY_START_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BAND_W-1:0]  s_band,
    input  logic [LEVEL_W-1:0] s_target_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BAND_W-1:0]  m_band_out,
    output logic [LEVEL_W-1:0] m_bar_level,
    output logic [LEVEL_W-1:0] m_roof_level
);

    localparam int unsigned ADDR_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [ROOF_W-1:0] LMAX = ROOF_W'(LEVEL_MAX);
    localparam entry_t RESET_ENTRY = '{bar: '0, roof: ROOF_RESET, vel: VEL_W'(VELOCITY_START)};

    // stage 1 registers
    logic               p1_valid_reg;
    logic [BAND_W-1:0]  p1_band_reg;
    logic [LEVEL_W-1:0] p1_tgt_reg;
    logic               p1_inrange_reg;
    logic               p1_hit_reg;
    logic               p1_adv;

    // bypass and valid bits
    entry_t             wr_data_reg;
    logic [BANDS-1:0]   init_reg;

    // output registers
    logic               m_valid_reg;
    logic [BAND_W-1:0]  m_band_reg;
    logic [LEVEL_W-1:0] m_bar_reg;
    logic [LEVEL_W-1:0] m_roof_reg;

    logic               s_accept;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;
    logic [LEVEL_W-1:0] tgt_clamp;
    entry_t             ram_rdata;
    entry_t             cur;
    entry_t             upd;
    logic [LEVEL_W-1:0] shown;

    logic [SUM_W-1:0]          avg_sum;
    logic [2*SUM_W-1:0]        avg_prod;
    logic [LEVEL_W-1:0]        bar_new;
    logic [VEL_W-1:0]          vel_excess;
    logic [QUOT_W-1:0]         vel_quot;
    logic [QUOT_W+15-1:0]      drop_prod;
    logic [ROOF_W+1:0]         drop;
    logic [ROOF_W+1:0]         roof_ext;

    assign s_accept = s_valid && s_ready;
    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign wr_en    = p1_adv && p1_inrange_reg;
    assign rd_addr  = ADDR_W'(s_band);
    assign wr_addr  = ADDR_W'(p1_band_reg);

    assign tgt_clamp = ({2'b00, s_target_level} > LMAX) ? LMAX[LEVEL_W-1:0] : s_target_level;

    bphb_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(BANDS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (upd),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // current state of the band: bypass, then ram, then reset value
    always_comb begin
        if (p1_hit_reg) begin
            cur = wr_data_reg;
        end else if (init_reg[wr_addr]) begin
            cur = ram_rdata;
        end else begin
            cur = RESET_ENTRY;
        end
    end

    // bar attack and decay
    always_comb begin
        avg_sum  = {1'b0, cur.bar, 1'b0} + SUM_W'(p1_tgt_reg);
        avg_prod = avg_sum * DIV3_MUL;
        if ({1'b0, p1_tgt_reg} > ({1'b0, cur.bar} + SMALL_RISE)) begin
            bar_new = avg_prod[DIV3_SHIFT +: LEVEL_W];
        end else if (p1_tgt_reg > cur.bar) begin
            bar_new = p1_tgt_reg;
        end else if ({1'b0, cur.bar} > ({1'b0, p1_tgt_reg} + 9'd1)) begin
            bar_new = cur.bar - 8'd1;
        end else begin
            bar_new = p1_tgt_reg;
        end
    end

    // roof fall from the stored velocity
    always_comb begin
        vel_excess = cur.vel - FALL_THRESHOLD;
        vel_quot   = vel_excess[VEL_W-1:2];
        drop_prod  = vel_quot * DIV5_MUL;
        if (cur.vel > FALL_THRESHOLD) begin
            drop = drop_prod[DIV5_SHIFT +: (ROOF_W + 2)];
        end else begin
            drop = '0;
        end
        roof_ext = {2'b00, cur.roof};
    end

    always_comb begin
        upd.bar = bar_new;
        if ({2'b00, bar_new} > cur.roof) begin
            // roof jumps to the bar, velocity restarts at 1 and steps to 2
            upd.roof = {2'b00, bar_new};
            upd.vel  = 16'd2;
            shown    = bar_new;
        end else begin
            shown = cur.roof[LEVEL_W-1:0];
            if (cur.vel == '0) begin
                upd.roof = cur.roof;
                upd.vel  = cur.vel;
            end else if (drop > roof_ext) begin
                upd.roof = '0;
                upd.vel  = '0;
            end else begin
                upd.roof = cur.roof - drop[ROOF_W-1:0];
                upd.vel  = (cur.vel == VEL_MAX) ? cur.vel : cur.vel + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_hit_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            init_reg     <= '0;
        end else begin
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
                // read and write of the same band at this edge: ram gives old data
                p1_hit_reg   <= wr_en && (wr_addr == rd_addr);
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                init_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_band_reg    <= s_band;
            p1_tgt_reg     <= tgt_clamp;
            p1_inrange_reg <= (32'(s_band) < BANDS);
        end
        if (wr_en) begin
            wr_data_reg <= upd;
        end
        if (p1_adv) begin
            m_band_reg <= p1_band_reg;
            m_bar_reg  <= p1_inrange_reg ? bar_new : '0;
            m_roof_reg <= p1_inrange_reg ? shown : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_band_out   = m_band_reg;
    assign m_bar_level  = m_bar_reg;
    assign m_roof_level = m_roof_reg;

endmodule
